// ===== sv/u8u7_pkg.sv =====
// u8u7_pkg: shared types, constants and the base64 character map for the
// UTF-8 to modified UTF-7 encoder. No dependencies.
`timescale 1ns / 1ps

package u8u7_pkg;

	localparam int MaxRes   = 6;	// most characters one input beat can produce
	localparam int ResCntW  = 3;
	localparam int CpW      = 21;

	localparam logic [6:0] AmpChar  = 7'h26;	// '&'
	localparam logic [6:0] DashChar = 7'h2D;	// '-'

	localparam logic [2:0] Lc0 = 3'd0;
	localparam logic [2:0] Lc2 = 3'd2;
	localparam logic [2:0] Lc4 = 3'd4;

	typedef struct packed {
		logic           run;	// base64 run open
		logic [2:0]     lc;	// pending bit count: 0, 2 or 4
		logic [3:0]     lb;	// pending bits, right aligned
		logic [1:0]     bse;	// continuation bytes still due
		logic [CpW-1:0] acc;	// code point being built
	} enc_state_t;

	typedef struct packed {
		logic [MaxRes-1:0][6:0] ch;
		logic [MaxRes-1:0]      bad;
		logic [ResCntW-1:0]     cnt;
	} res_list_t;

	// "A..Za..z0..9+," alphabet
	function automatic logic [6:0] b64_char(input logic [5:0] v);
		logic [6:0] r;
		if (v < 6'd26)
			r = 7'h41 + {1'b0, v};
		else if (v < 6'd52)
			r = 7'h61 + {1'b0, v} - 7'd26;
		else if (v < 6'd62)
			r = 7'h30 + {1'b0, v} - 7'd52;
		else if (v == 6'd62)
			r = 7'h2B;
		else
			r = 7'h2C;
		return r;
	endfunction

endpackage

// ===== sv/u8u7_if.sv =====
// u8u7_if: valid/ready channel interfaces for input bytes and output characters.
// Standalone; no package dependency.
`timescale 1ns / 1ps

interface u8u7_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       end_of_name;

	modport source (output valid, code_byte, end_of_name, input ready);
	modport sink (input valid, code_byte, end_of_name, output ready);
endinterface

interface u8u7_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_char;
	logic       malformed;
	logic       last_of_run;

	modport source (output valid, out_char, malformed, last_of_run, input ready);
	modport sink (input valid, out_char, malformed, last_of_run, output ready);
endinterface

// ===== sv/u8u7_encode.sv =====
// u8u7_encode: combinational step of the encoder; from the current state and
// one input beat it builds the next state and the list of output characters.
// Depends on u8u7_pkg.
`timescale 1ns / 1ps

module u8u7_encode (
	input  u8u7_pkg::enc_state_t st,
	input  logic [7:0]           code_byte,
	input  logic                 end_of_name,
	output u8u7_pkg::enc_state_t nst,
	output u8u7_pkg::res_list_t  lst
);

	logic                      pre_bad, do_close, do_emit, pair;
	logic                      post_amp, post_char, post_bad;
	logic [15:0]               u1, u2;
	logic [u8u7_pkg::CpW-1:0]  acc_n;
	logic [u8u7_pkg::CpW-1:0]  cp_off;
	logic                      run;
	logic [2:0]                lc;
	logic [3:0]                lb;
	logic [35:0]               w;
	logic [2:0]                n_ch;
	logic [2:0]                rem;
	logic [3:0]                lb_new;
	logic [2:0]                idx;

	// decode the beat into actions
	always_comb begin
		nst       = st;
		pre_bad   = 1'b0;
		do_close  = 1'b0;
		do_emit   = 1'b0;
		pair      = 1'b0;
		post_amp  = 1'b0;
		post_char = 1'b0;
		post_bad  = 1'b0;
		u1        = '0;
		u2        = '0;
		acc_n     = {st.acc[u8u7_pkg::CpW-7:0], code_byte[5:0]};
		cp_off    = acc_n - 21'h10000;
		if (end_of_name) begin
			pre_bad  = (st.bse != 2'd0);
			do_close = 1'b1;
		end else if (st.bse != 2'd0) begin
			if (code_byte[7:6] == 2'b10) begin
				nst.bse = st.bse - 2'd1;
				nst.acc = acc_n;
				if (st.bse == 2'd1) begin
					nst.acc = '0;
					if (acc_n < 21'h10000) begin
						do_emit = 1'b1;
						u1      = acc_n[15:0];
					end else if (acc_n <= 21'h10FFFF) begin
						do_emit = 1'b1;
						pair    = 1'b1;
						u1      = {6'b110110, cp_off[19:10]};
						u2      = {6'b110111, cp_off[9:0]};
					end else begin
						post_bad = 1'b1;
					end
				end
			end else begin
				nst.bse  = 2'd0;
				nst.acc  = '0;
				post_bad = 1'b1;
			end
		end else if (code_byte == {1'b0, u8u7_pkg::AmpChar}) begin
			do_close = 1'b1;
			post_amp = 1'b1;
		end else if (code_byte >= 8'h20 && code_byte <= 8'h7E) begin
			do_close  = 1'b1;
			post_char = 1'b1;
		end else if (code_byte < 8'h20 || code_byte == 8'h7F) begin
			do_emit = 1'b1;
			u1      = {8'h00, code_byte};
		end else if (code_byte[7:5] == 3'b110) begin
			nst.bse = 2'd1;
			nst.acc = {16'b0, code_byte[4:0]};
		end else if (code_byte[7:4] == 4'b1110) begin
			nst.bse = 2'd2;
			nst.acc = {17'b0, code_byte[3:0]};
		end else if (code_byte[7:3] == 5'b11110) begin
			nst.bse = 2'd3;
			nst.acc = {18'b0, code_byte[2:0]};
		end else begin
			post_bad = 1'b1;
		end

		// build the character list in output order
		lst = '0;
		idx = '0;
		run = st.run;
		lc  = st.lc;
		lb  = st.lb;
		w      = '0;
		n_ch   = '0;
		rem    = '0;
		lb_new = '0;

		if (pre_bad) begin
			lst.bad[idx] = 1'b1;
			idx = idx + 3'd1;
		end

		if (do_close && run) begin
			if (lc == u8u7_pkg::Lc2) begin
				lst.ch[idx] = u8u7_pkg::b64_char({lb[1:0], 4'b0});
				idx = idx + 3'd1;
			end else if (lc == u8u7_pkg::Lc4) begin
				lst.ch[idx] = u8u7_pkg::b64_char({lb, 2'b0});
				idx = idx + 3'd1;
			end
			lst.ch[idx] = u8u7_pkg::DashChar;
			idx = idx + 3'd1;
			run = 1'b0;
			lc  = '0;
			lb  = '0;
		end

		if (do_emit) begin
			if (!run) begin
				lst.ch[idx] = u8u7_pkg::AmpChar;
				idx = idx + 3'd1;
				run = 1'b1;
				lc  = '0;
				lb  = '0;
			end
			// pending bits and units, left aligned in a 36-bit window
			case (lc)
				u8u7_pkg::Lc2: begin
					if (pair) begin
						w = {lb[1:0], u1, u2, 2'b0};  n_ch = 3'd5; rem = 3'd4;
						lb_new = u2[3:0];
					end else begin
						w = {lb[1:0], u1, 18'b0};     n_ch = 3'd3; rem = 3'd0;
						lb_new = 4'd0;
					end
				end
				u8u7_pkg::Lc4: begin
					if (pair) begin
						w = {lb, u1, u2};             n_ch = 3'd6; rem = 3'd0;
						lb_new = 4'd0;
					end else begin
						w = {lb, u1, 16'b0};          n_ch = 3'd3; rem = 3'd2;
						lb_new = {2'b0, u1[1:0]};
					end
				end
				default: begin
					if (pair) begin
						w = {u1, u2, 4'b0};           n_ch = 3'd5; rem = 3'd2;
						lb_new = {2'b0, u2[1:0]};
					end else begin
						w = {u1, 20'b0};              n_ch = 3'd2; rem = 3'd4;
						lb_new = u1[3:0];
					end
				end
			endcase
			for (int k = 0; k < u8u7_pkg::MaxRes; k++) begin
				if (k < int'(n_ch)) begin
					lst.ch[idx] = u8u7_pkg::b64_char(6'(w >> (30 - 6 * k)));
					idx = idx + 3'd1;
				end
			end
			lc = rem;
			lb = lb_new;
		end

		if (post_amp) begin
			lst.ch[idx] = u8u7_pkg::AmpChar;
			idx = idx + 3'd1;
			lst.ch[idx] = u8u7_pkg::DashChar;
			idx = idx + 3'd1;
		end
		if (post_char) begin
			lst.ch[idx] = code_byte[6:0];
			idx = idx + 3'd1;
		end
		if (post_bad) begin
			lst.bad[idx] = 1'b1;
			idx = idx + 3'd1;
		end

		lst.cnt = idx;
		nst.run = run;
		nst.lc  = lc;
		nst.lb  = lb;
		if (end_of_name)
			nst = '0;
	end

endmodule

// ===== sv/u8u7_serial.sv =====
// u8u7_serial: result register holding one beat's character list and
// handing it out one character per output beat. Depends on u8u7_pkg, u8u7_if.
`timescale 1ns / 1ps

module u8u7_serial (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  u8u7_pkg::res_list_t lst,
	output logic                free,
	u8u7_out_if.source          egress
);

	u8u7_pkg::res_list_t           list_q;
	logic [u8u7_pkg::ResCntW-1:0]  rem_q;
	logic [u8u7_pkg::ResCntW-1:0]  pos_q;
	logic                          fire;

	assign egress.valid       = (rem_q != '0);
	assign egress.out_char    = list_q.ch[pos_q];
	assign egress.malformed   = list_q.bad[pos_q];
	assign egress.last_of_run = (rem_q == 3'd1);
	assign fire = egress.valid && egress.ready;
	assign free = (rem_q == '0) || (rem_q == 3'd1 && egress.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			pos_q <= '0;
		end else if (load) begin
			rem_q <= lst.cnt;
			pos_q <= '0;
		end else if (fire) begin
			rem_q <= rem_q - 3'd1;
			pos_q <= pos_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			list_q <= lst;
	end

endmodule

// ===== sv/utf8_to_modified_utf7_encoder_core.sv =====
// utf8_to_modified_utf7_encoder_core: top level of the UTF-8 to IMAP modified
// UTF-7 encoder. Depends on u8u7_pkg, u8u7_if, u8u7_encode, u8u7_serial.
`timescale 1ns / 1ps

// Usage
//   ingress: one UTF-8 byte per beat (code_byte), or an end beat
//     (end_of_name = 1) that closes an open base64 run and clears all state.
//   egress: one ASCII character per beat. malformed flags a beat that carries
//     no character (bad UTF-8); last_of_run marks the final character caused
//     by one input beat. A beat that causes nothing (lead byte, continuation
//     byte mid-sequence, end beat with nothing open) gives no output.
// Path: an input beat is registered in the input stage, encoded combinationally
//   and loaded into the result register once that register is free; its first
//   character is then offered straight from the result register.
// Throughput: one input beat per cycle while each beat yields at most one
//   character and egress.ready stays high. A beat yielding several characters
//   (up to 6, e.g. a supplementary character opening a run) holds the
//   single-character output port until all are taken; the next beat waits.
// Reset: arst_n clears the input stage, the encoder state and the result
//   register count; no beat is offered until a new byte arrives.
// Stall: while egress.ready is low the current character holds; the input
//   stage keeps one more beat, then ingress.ready drops.

module utf8_to_modified_utf7_encoder_core (
	input  logic       clk,
	input  logic       arst_n,
	u8u7_in_if.sink    ingress,
	u8u7_out_if.source egress
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 eon_s1;
	u8u7_pkg::enc_state_t state_q;
	u8u7_pkg::enc_state_t state_nx;
	u8u7_pkg::res_list_t  lst;
	logic                 free;
	logic                 consume;

	// input stage moves on when the result register can take its list
	assign consume       = valid_s1 && free;
	assign ingress.ready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ingress.ready) begin
			valid_s1 <= ingress.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ingress.valid && ingress.ready) begin
			byte_s1 <= ingress.code_byte;
			eon_s1  <= ingress.end_of_name;
		end
	end

	// run / leftover bits / partial character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (consume) begin
			state_q <= state_nx;
		end
	end

	u8u7_encode u_enc (
		.st          (state_q),
		.code_byte   (byte_s1),
		.end_of_name (eon_s1),
		.nst         (state_nx),
		.lst         (lst)
	);

	u8u7_serial u_ser (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (consume),
		.lst    (lst),
		.free   (free),
		.egress (egress)
	);

endmodule

// ===== sv/u8u7_checker.sv =====
// u8u7_checker: port-level assertions for the encoder top level, attached by
// bind. Depends on utf8_to_modified_utf7_encoder_core and u8u7_if.
`timescale 1ns / 1ps

module u8u7_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] out_char,
	input logic       malformed,
	input logic       last_of_run
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			$stable(out_char) && $stable(malformed) && $stable(last_of_run))
		else $error("output payload changed while stalled");

	a_bad_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && malformed |-> out_char == 7'h00)
		else $error("malformed beat carries a character");

	a_printable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !malformed |-> out_char >= 7'h20 && out_char != 7'h7F)
		else $error("non-printable character on output");

endmodule

bind utf8_to_modified_utf7_encoder_core u8u7_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (egress.valid),
	.out_ready   (egress.ready),
	.out_char    (egress.out_char),
	.malformed   (egress.malformed),
	.last_of_run (egress.last_of_run)
);

// ===== test/utf7_checker.sv =====
`timescale 1ns / 1ps
// utf7_checker: watches the byte and character channels of the encoder, predicts
// the modified UTF-7 characters of every accepted beat and compares them in order.
// Depends on u8u7_pkg and u8u7_if.

module utf7_checker (
	input  logic clk,
	input  logic arst_n,
	u8u7_in_if   ingress,
	u8u7_out_if  egress,
	output int   errors,
	output int   pending
);

	localparam logic [511:0] B64_MAP =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+,";
	localparam int          MAX_CHARS = 6;
	localparam logic [7:0]  AMP_BYTE  = 8'h26;
	localparam logic [20:0] BMP_END   = 21'h10000;
	localparam logic [20:0] CP_TOP    = 21'h10FFFF;

	typedef struct packed {
		logic [6:0] ch;
		logic       bad;
		logic       last;
	} utf7_char_t;

	utf7_char_t due_q[$];

	// predicted encoder state
	logic        run_open;
	logic [2:0]  pend_cnt;
	logic [3:0]  pend_bits;
	logic [1:0]  cont_due;
	logic [20:0] cp_acc;

	utf7_char_t beat_chars [MAX_CHARS];
	int         beat_n;
	int         chars_seen;

	function automatic logic [6:0] b64_at(input logic [5:0] v);
		return B64_MAP[8 * (63 - int'(v)) +: 7];
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: char %0d %s mismatch: got 0x%0h, expected 0x%0h",
			$time, chars_seen, what, got, want);
		errors++;
	endtask

	task automatic add_char(input logic [6:0] c, input logic bad);
		if (beat_n < MAX_CHARS) begin
			beat_chars[beat_n] = '{ch: c, bad: bad, last: 1'b0};
			beat_n++;
		end
	endtask

	task automatic close_run();
		if (run_open) begin
			if (pend_cnt == u8u7_pkg::Lc2)
				add_char(b64_at({pend_bits[1:0], 4'b0}), 1'b0);
			else if (pend_cnt == u8u7_pkg::Lc4)
				add_char(b64_at({pend_bits, 2'b0}), 1'b0);
			add_char(u8u7_pkg::DashChar, 1'b0);
			run_open  = 1'b0;
			pend_cnt  = u8u7_pkg::Lc0;
			pend_bits = '0;
		end
	endtask

	task automatic put_unit(input logic [15:0] unit);
		logic [19:0] bits;
		int          nbits;
		if (!run_open) begin
			add_char(u8u7_pkg::AmpChar, 1'b0);
			run_open  = 1'b1;
			pend_cnt  = u8u7_pkg::Lc0;
			pend_bits = '0;
		end
		nbits = int'(pend_cnt) + 16;
		bits  = {pend_bits, unit};
		while (nbits >= 6) begin
			add_char(b64_at(6'((bits >> (nbits - 6)) & 20'h3F)), 1'b0);
			nbits -= 6;
		end
		pend_cnt  = 3'(nbits);
		pend_bits = 4'(bits & ((20'd1 << nbits) - 20'd1));
	endtask

	task automatic put_code_point(input logic [20:0] cp);
		logic [20:0] v;
		if (cp < BMP_END) begin
			put_unit(cp[15:0]);
		end else if (cp <= CP_TOP) begin
			v = cp - BMP_END;
			put_unit({6'b110110, v[19:10]});
			put_unit({6'b110111, v[9:0]});
		end else begin
			add_char(7'h00, 1'b1);
		end
	endtask

	task automatic encode_beat(input logic [7:0] b, input logic eon);
		beat_n = 0;
		if (eon) begin
			if (cont_due != 2'd0)
				add_char(7'h00, 1'b1);
			close_run();
			cont_due = 2'd0;
			cp_acc   = '0;
		end else if (cont_due != 2'd0) begin
			if (b[7:6] == 2'b10) begin
				cp_acc = {cp_acc[14:0], b[5:0]};
				cont_due--;
				if (cont_due == 2'd0) begin
					put_code_point(cp_acc);
					cp_acc = '0;
				end
			end else begin
				// sequence cut short: partial character and this byte are lost
				cont_due = 2'd0;
				cp_acc   = '0;
				add_char(7'h00, 1'b1);
			end
		end else if (b == AMP_BYTE) begin
			close_run();
			add_char(u8u7_pkg::AmpChar, 1'b0);
			add_char(u8u7_pkg::DashChar, 1'b0);
		end else if (b >= 8'h20 && b <= 8'h7E) begin
			close_run();
			add_char(b[6:0], 1'b0);
		end else if (b < 8'h20 || b == 8'h7F) begin
			put_unit({8'h00, b});
		end else if (b[7:5] == 3'b110) begin
			cont_due = 2'd1;
			cp_acc   = {16'b0, b[4:0]};
		end else if (b[7:4] == 4'b1110) begin
			cont_due = 2'd2;
			cp_acc   = {17'b0, b[3:0]};
		end else if (b[7:3] == 5'b11110) begin
			cont_due = 2'd3;
			cp_acc   = {18'b0, b[2:0]};
		end else begin
			add_char(7'h00, 1'b1);
		end
		if (beat_n > 0)
			beat_chars[beat_n - 1].last = 1'b1;
		for (int i = 0; i < beat_n; i++)
			due_q.push_back(beat_chars[i]);
	endtask

	always @(posedge clk) begin
		utf7_char_t want;
		if (!arst_n) begin
			run_open   = 1'b0;
			pend_cnt   = u8u7_pkg::Lc0;
			pend_bits  = '0;
			cont_due   = 2'd0;
			cp_acc     = '0;
			errors     = 0;
			chars_seen = 0;
			due_q.delete();
		end else begin
			// compare first: a character can never stem from a beat taken at this edge
			if (egress.valid && egress.ready) begin
				if (due_q.size() == 0) begin
					report_mismatch("unexpected", int'(egress.out_char), 0);
				end else begin
					want = due_q.pop_front();
					if (egress.out_char !== want.ch)
						report_mismatch("out_char", int'(egress.out_char), int'(want.ch));
					if (egress.malformed !== want.bad)
						report_mismatch("malformed", int'(egress.malformed), int'(want.bad));
					if (egress.last_of_run !== want.last)
						report_mismatch("last_of_run", int'(egress.last_of_run),
							int'(want.last));
				end
				chars_seen++;
			end
			if (ingress.valid && ingress.ready)
				encode_beat(ingress.code_byte, ingress.end_of_name);
		end
		pending = due_q.size();
	end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// testbench: drives the UTF-8 to modified UTF-7 encoder with directed and random
// mailbox names under varying backpressure and prints the verdict.
// Depends on u8u7_if, utf7_checker and utf8_to_modified_utf7_encoder_core.

module testbench;

	localparam int RANDOM_BYTES = 180;
	localparam int HOLD_CYCLES  = 300;	// long egress hold-off, fills the input stage
	localparam int DRAIN_CYCLES = 20;	// settle time after the checker queue is empty
	localparam int NUM_DIRECTED = 25;

	// bit 8 marks an end-of-name beat
	localparam logic [8:0] END_BEAT = 9'h100;
	localparam logic [8:0] DIRECTED [NUM_DIRECTED] = '{
		9'h020, 9'h07E,			// printable extremes
		9'h026,				// '&' escapes to "&-"
		9'h000, 9'h07F,			// controls open a base64 run
		9'h0C3, 9'h0A9,			// two-byte character inside the run
		9'h0F0, 9'h09F, 9'h098, 9'h080,	// supplementary: surrogate pair
		9'h080,				// stray continuation, run stays open
		9'h0FF,				// invalid lead
		9'h0C3, 9'h041,			// sequence broken by a non-continuation
		9'h0F4, 9'h090, 9'h080, 9'h080,	// code point above the Unicode range
		9'h0ED, 9'h0A0, 9'h080,		// lone surrogate, encoded by value
		9'h0E2, END_BEAT,		// end while a character is pending
		END_BEAT			// end with nothing open
	};

	logic clk = 1'b0;
	logic arst_n;

	int phase;
	int send_idle_pct;
	int recv_idle_pct;
	int bytes_sent;
	int errors;
	int pending;

	u8u7_in_if  ingress ();
	u8u7_out_if egress ();

	utf8_to_modified_utf7_encoder_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.ingress(ingress),
		.egress (egress)
	);

	// prediction and comparison live in the checker; this module only makes
	// stimulus and reads the failure count at the end
	utf7_checker u_check (
		.clk    (clk),
		.arst_n (arst_n),
		.ingress(ingress),
		.egress (egress),
		.errors (errors),
		.pending(pending)
	);

	always #5 clk = ~clk;

	// Offer one beat on ingress, with random idle cycles ahead of it. Called at a
	// rising edge; returns at the edge where the beat is taken, so the next call
	// drives valid only once in that step.
	task automatic send_beat(input logic [7:0] b, input logic eon);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			ingress.valid <= 1'b0;
			@(posedge clk);
		end
		ingress.valid       <= 1'b1;
		ingress.code_byte   <= b;
		ingress.end_of_name <= eon;
		@(posedge clk);
		while (!ingress.ready)
			@(posedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_beat(b, 1'b0);
		bytes_sent++;
	endtask

	// end beats carry a random, ignored code byte
	task automatic send_end();
		send_beat(8'($urandom_range(0, 255)), 1'b1);
	endtask

	function automatic logic [7:0] lead_byte(input int len);
		logic [7:0] b;
		case (len)
			2: begin
				b = {3'b110, 5'($urandom_range(0, 31))};
			end
			3: begin
				b = {4'b1110, 4'($urandom_range(0, 15))};
			end
			default: begin
				b = {5'b11110, 3'($urandom_range(0, 7))};
			end
		endcase
		return b;
	endfunction

	function automatic logic [7:0] cont_byte();
		return {2'b10, 6'($urandom_range(0, 63))};
	endfunction

	// One random character of a name. Mostly well-formed UTF-8 so the run and
	// leftover-bit logic gets exercised deeply; the rest is noise, broken
	// sequences and names that end mid-character.
	task automatic send_random_char();
		int         pick;
		int         len;
		int         keep;
		logic [7:0] b;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			send_byte(8'($urandom_range(32, 126)));
		end else if (pick < 36) begin
			send_byte(8'h26);
		end else if (pick < 44) begin
			send_byte(($urandom_range(0, 3) == 0) ? 8'h7F : 8'($urandom_range(0, 31)));
		end else if (pick < 86) begin
			len = $urandom_range(2, 4);
			send_byte(lead_byte(len));
			for (int i = 1; i < len; i++)
				send_byte(cont_byte());
		end else if (pick < 92) begin
			send_byte(8'($urandom_range(0, 255)));
		end else if (pick < 96) begin
			// lead, too few continuations, then any non-continuation byte
			len  = $urandom_range(2, 4);
			keep = $urandom_range(0, len - 2);
			send_byte(lead_byte(len));
			for (int i = 0; i < keep; i++)
				send_byte(cont_byte());
			b = 8'($urandom_range(0, 255));
			if (b[7:6] == 2'b10)
				b[6] = 1'b1;
			send_byte(b);
		end else begin
			len  = $urandom_range(2, 4);
			keep = $urandom_range(0, len - 2);
			send_byte(lead_byte(len));
			for (int i = 0; i < keep; i++)
				send_byte(cont_byte());
			send_end();
		end
		if ($urandom_range(0, 99) < 8)
			send_end();
	endtask

	// Egress side: random ready, plus one long hold-off in the last phase while
	// the sender keeps offering beats, so the block backs up into ingress.
	initial begin
		int hold_left;
		bit hold_done;
		hold_left    = 0;
		hold_done    = 1'b0;
		egress.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				egress.ready <= 1'b0;
				hold_left--;
			end else if (!hold_done && phase == 2) begin
				hold_done    = 1'b1;
				hold_left    = HOLD_CYCLES - 1;
				egress.ready <= 1'b0;
			end else begin
				egress.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Stimulus and verdict
	initial begin
		arst_n              = 1'b0;
		ingress.valid       = 1'b0;
		ingress.code_byte   = 8'h00;
		ingress.end_of_name = 1'b0;
		phase               = 0;
		send_idle_pct       = 15;
		recv_idle_pct       = 82;
		bytes_sent          = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats under the first idle mix
		for (int i = 0; i < NUM_DIRECTED; i++)
			send_beat(DIRECTED[i][7:0], DIRECTED[i][8]);

		// random names, one third per idle mix:
		// sender light / receiver heavy, then swapped, then no idling at all
		for (int p = 0; p < 3; p++) begin
			phase = p;
			case (p)
				0: begin
					send_idle_pct = 15;
					recv_idle_pct = 82;
				end
				1: begin
					send_idle_pct = 82;
					recv_idle_pct = 15;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			bytes_sent = 0;
			while (bytes_sent < RANDOM_BYTES / 3 + 1)
				send_random_char();
			send_end();
		end
		ingress.valid <= 1'b0;

		// drain: let the checker see the last beat, then wait for every character
		repeat (2) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#5000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/u8u7_pkg.sv
sv/u8u7_if.sv
sv/u8u7_encode.sv
sv/u8u7_serial.sv
sv/utf8_to_modified_utf7_encoder_core.sv
sv/u8u7_checker.sv
test/utf7_checker.sv
test/testbench.sv
